FILE: hw/rtl/hpse_pkg.sv
// Package for the Hall period speed estimator.
// Holds the shared types, the register map and the controller states.
// No dependencies.
`timescale 1ns / 1ps

package hpse_pkg;

	// Default period width taken from the capture timer
	localparam int PERIOD_WIDTH_DEF = 16;

	// Field widths
	localparam int PER_W   = 16;
	localparam int SPEED_W = 16;
	localparam int CONST_W = 32;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// Radix-2 divider: one quotient bit per step
	localparam int DIV_STEPS = 16;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// Register map, word index (paddr[3:2])
	localparam logic [1:0] REG_PERIOD_LO      = 2'd0;
	localparam logic [1:0] REG_PERIOD_HI      = 2'd1;
	localparam logic [1:0] REG_SPEED_CONSTANT = 2'd2;

	// Reset values
	localparam logic [PER_W-1:0]   PERIOD_LO_RST      = 16'd100;
	localparam logic [PER_W-1:0]   PERIOD_HI_RST      = 16'hFFFF;
	localparam logic [CONST_W-1:0] SPEED_CONSTANT_RST = 32'd1000000;

	localparam logic [SPEED_W-1:0] SPEED_SAT = '1;

	typedef struct packed {
		logic [PER_W-1:0]   period_lo;
		logic [PER_W-1:0]   period_hi;
		logic [CONST_W-1:0] speed_constant;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;        // item accepted this cycle
		logic capture;     // accepted item carries a new period
		logic div_init;    // load divider from speed constant
		logic div_step;    // one restoring division step
		logic speed_load;  // write quotient into stored speed
		logic out_load;    // move stored values into output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;    // output register can take a result
	} stat_t;

endpackage

FILE: hw/rtl/hpse_regs.sv
// Configuration register file for the Hall period speed estimator.
// APB-style write/read port; depends on hpse_pkg.
`timescale 1ns / 1ps

module hpse_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hpse_pkg::ADDR_W-1:0] paddr,
	input  logic [hpse_pkg::DATA_W-1:0] pwdata,
	output logic [hpse_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output hpse_pkg::cfg_t              cfg
);

	hpse_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_lo      <= hpse_pkg::PERIOD_LO_RST;
			cfg_q.period_hi      <= hpse_pkg::PERIOD_HI_RST;
			cfg_q.speed_constant <= hpse_pkg::SPEED_CONSTANT_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				hpse_pkg::REG_PERIOD_LO: begin
					cfg_q.period_lo <= pwdata[hpse_pkg::PER_W-1:0];
				end
				hpse_pkg::REG_PERIOD_HI: begin
					cfg_q.period_hi <= pwdata[hpse_pkg::PER_W-1:0];
				end
				hpse_pkg::REG_SPEED_CONSTANT: begin
					cfg_q.speed_constant <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (paddr[3:2])
			hpse_pkg::REG_PERIOD_LO:      prdata = {16'd0, cfg_q.period_lo};
			hpse_pkg::REG_PERIOD_HI:      prdata = {16'd0, cfg_q.period_hi};
			hpse_pkg::REG_SPEED_CONSTANT: prdata = cfg_q.speed_constant;
			default:                      prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/hpse_ctrl.sv
// Controller state machine for the Hall period speed estimator.
// Sequences accept, divider steps and result output; depends on hpse_pkg.
`timescale 1ns / 1ps

module hpse_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            capture,
	output logic            s_tready,
	input  hpse_pkg::stat_t stat,
	output hpse_pkg::cmd_t  cmd
);

	hpse_pkg::state_t              state_q;
	hpse_pkg::state_t              state_d;
	logic [hpse_pkg::CNT_W-1:0]    cnt_q;
	logic                          last_step;

	assign last_step = (cnt_q == hpse_pkg::CNT_W'(hpse_pkg::DIV_STEPS - 1));

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hpse_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == hpse_pkg::S_DIV) begin
			cnt_q <= cnt_q + 1'b1;
		end else begin
			cnt_q <= '0;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			hpse_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load    = 1'b1;
					cmd.capture = capture;
					state_d     = capture ? hpse_pkg::S_START : hpse_pkg::S_OUT;
				end
			end
			hpse_pkg::S_START: begin
				cmd.div_init = 1'b1;
				state_d      = hpse_pkg::S_DIV;
			end
			hpse_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) begin
					state_d = hpse_pkg::S_FIN;
				end
			end
			hpse_pkg::S_FIN: begin
				cmd.speed_load = 1'b1;
				state_d        = hpse_pkg::S_OUT;
			end
			hpse_pkg::S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = hpse_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = hpse_pkg::S_IDLE;
			end
		endcase
	end

	// A capture item runs the divider, a plain item goes straight to output
	a_accept_route: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=>
		((state_q == hpse_pkg::S_START) == $past(capture)) &&
		((state_q == hpse_pkg::S_OUT) == !$past(capture)))
		else $error("accepted item routed to wrong state");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hpse_pkg::S_DIV && last_step) |=> state_q == hpse_pkg::S_FIN)
		else $error("divider did not finish after its last step");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded while output register busy");

endmodule

FILE: hw/rtl/hpse_dp.sv
// Datapath for the Hall period speed estimator: weighted average, clamp,
// radix-2 divider with saturation and output register. Depends on hpse_pkg.
`timescale 1ns / 1ps

module hpse_dp #(
	parameter int PERIOD_WIDTH = hpse_pkg::PERIOD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hpse_pkg::cmd_t               cmd,
	input  hpse_pkg::cfg_t               cfg,
	input  logic [hpse_pkg::PER_W-1:0]   period,
	output hpse_pkg::stat_t              stat,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata
);

	localparam int EFF_W = (PERIOD_WIDTH < hpse_pkg::PER_W) ? PERIOD_WIDTH : hpse_pkg::PER_W;
	localparam logic [hpse_pkg::PER_W-1:0] PER_MASK =
		hpse_pkg::PER_W'((64'd1 << EFF_W) - 64'd1);

	logic [hpse_pkg::PER_W-1:0]   avg_q;
	logic [hpse_pkg::PER_W-1:0]   prev_q;
	logic [hpse_pkg::SPEED_W-1:0] speed_q;
	logic [hpse_pkg::PER_W-1:0]   rem_q;
	logic [hpse_pkg::PER_W-1:0]   num_lo_q;
	logic [hpse_pkg::SPEED_W-1:0] quo_q;
	logic                         sat_q;
	logic                         m_tvalid_q;
	logic [31:0]                  m_tdata_q;

	logic [hpse_pkg::PER_W-1:0]   p_m;
	logic [17:0]                  sum;
	logic [hpse_pkg::PER_W-1:0]   avg_raw;
	logic [hpse_pkg::PER_W-1:0]   avg_clamp;
	logic [17:0]                  trial;
	logic                         fits;

	// Weighted average of old average, previous and new period, then clamp
	always_comb begin
		p_m     = period & PER_MASK;
		sum     = 18'(avg_q) + 18'(prev_q) + {1'b0, p_m, 1'b0};
		avg_raw = sum[17:2];
		if (avg_raw < cfg.period_lo) begin
			avg_clamp = cfg.period_lo;
		end else if (avg_raw > cfg.period_hi) begin
			avg_clamp = cfg.period_hi;
		end else begin
			avg_clamp = avg_raw;
		end
	end

	// Restoring division trial subtract
	assign trial = {1'b0, rem_q, num_lo_q[hpse_pkg::PER_W-1]} - {2'b00, avg_q};
	assign fits  = ~trial[17];

	// Stored state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q   <= '0;
			prev_q  <= '0;
			speed_q <= '0;
		end else begin
			if (cmd.load && cmd.capture) begin
				avg_q  <= avg_clamp;
				prev_q <= p_m;
			end
			if (cmd.speed_load) begin
				speed_q <= sat_q ? hpse_pkg::SPEED_SAT : quo_q;
			end
		end
	end

	// Divider: high half >= divisor means quotient overflows (also zero divisor)
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q    <= cfg.speed_constant[31:16];
			num_lo_q <= cfg.speed_constant[15:0];
			sat_q    <= (cfg.speed_constant[31:16] >= avg_q);
			quo_q    <= '0;
		end else if (cmd.div_step) begin
			rem_q    <= fits ? trial[15:0] : {rem_q[14:0], num_lo_q[hpse_pkg::PER_W-1]};
			num_lo_q <= {num_lo_q[14:0], 1'b0};
			quo_q    <= {quo_q[14:0], fits};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {avg_q, speed_q};
		end
	end

	assign stat.out_free = ~m_tvalid_q | m_tready;
	assign m_tvalid      = m_tvalid_q;
	assign m_tdata       = m_tdata_q;

	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid_q && (m_tdata_q == {$past(avg_q), $past(speed_q)}))
		else $error("output register not loaded with stored values");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && cmd.capture && cfg.period_lo <= cfg.period_hi) |=>
		(avg_q >= $past(cfg.period_lo) && avg_q <= $past(cfg.period_hi)))
		else $error("average outside clamp range");

endmodule

FILE: hw/rtl/hall_period_speed_estimator_unit.sv
// Top level of the Hall period speed estimator.
// Instantiates hpse_regs, hpse_ctrl and hpse_dp; depends on hpse_pkg.
`timescale 1ns / 1ps

// One item in, one item out. An item with new_capture set updates the
// weighted average (old average + previous period + 2*period) / 4, clamps
// it to [period_lo, period_hi] and divides speed_constant by it with a
// radix-2 restoring divider, one quotient bit per cycle; the quotient
// saturates at 65535, as does a zero average. Such an item goes through
// accept, divider setup, 16 divider steps, speed update and output load.
// An item without a capture returns the stored speed and average. One
// item is in work at a time; the output register lets the next item be
// taken while a result waits on m_tready.
// Registers: 0x0 period_lo, 0x4 period_hi, 0x8 speed_constant.

module hall_period_speed_estimator_unit #(
	parameter int PERIOD_WIDTH = hpse_pkg::PERIOD_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,  // [15:0] period
	input  logic                        s_tuser,  // [0] new_capture
	// Output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,  // [15:0] speed, [31:16] average_period
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hpse_pkg::ADDR_W-1:0] paddr,
	input  logic [hpse_pkg::DATA_W-1:0] pwdata,
	output logic [hpse_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	hpse_pkg::cfg_t  cfg;
	hpse_pkg::cmd_t  cmd;
	hpse_pkg::stat_t stat;

	hpse_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hpse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.capture  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hpse_dp #(
		.PERIOD_WIDTH (PERIOD_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.period   (s_tdata),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: tb/hpse_speed_checker.sv
// Checker for the Hall period speed estimator: watches both streams and the
// register port, predicts each result and compares it. Depends on hpse_pkg.
`timescale 1ns / 1ps

module hpse_speed_checker
	import hpse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [15:0]       s_tdata,  // [15:0] period
	input  logic              s_tuser,  // [0] new_capture
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [31:0]       m_tdata,  // [15:0] speed, [31:16] average_period
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [PER_W-1:0]   average_period;
	} speed_result_t;

	// Own copy of the registers and the estimator state
	cfg_t               cfg;
	logic [PER_W-1:0]   avg_q;
	logic [PER_W-1:0]   prev_q;
	logic [SPEED_W-1:0] speed_q;

	speed_result_t speed_expect_q[$];
	speed_result_t exp_r;
	speed_result_t got_r;

	// One capture: weighted average, clamp, then saturating division
	function automatic void update_speed_estimate(input logic [PER_W-1:0] per);
		logic [PER_W+1:0]   wsum;
		logic [PER_W-1:0]   avg_c;
		logic [CONST_W-1:0] quo;
		wsum  = {2'b00, avg_q} + {2'b00, prev_q} + {1'b0, per, 1'b0};
		avg_c = wsum[PER_W+1:2];
		prev_q = per;
		// Lower bound is checked first: with crossed bounds, an average below it gets period_lo, any other period_hi
		if (avg_c < cfg.period_lo) begin
			avg_c = cfg.period_lo;
		end else if (avg_c > cfg.period_hi) begin
			avg_c = cfg.period_hi;
		end
		avg_q = avg_c;
		if (avg_c == '0) begin
			speed_q = SPEED_SAT;
		end else begin
			quo = cfg.speed_constant / {16'd0, avg_c};
			speed_q = (quo > {16'd0, SPEED_SAT}) ? SPEED_SAT : quo[SPEED_W-1:0];
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.period_lo      = PERIOD_LO_RST;
			cfg.period_hi      = PERIOD_HI_RST;
			cfg.speed_constant = SPEED_CONSTANT_RST;
			avg_q   = '0;
			prev_q  = '0;
			speed_q = '0;
			speed_expect_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			// Register writes; upper bits of the narrow registers are dropped
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PERIOD_LO:      cfg.period_lo      = pwdata[PER_W-1:0];
					REG_PERIOD_HI:      cfg.period_hi      = pwdata[PER_W-1:0];
					REG_SPEED_CONSTANT: cfg.speed_constant = pwdata;
					default: ;
				endcase
			end

			// Compare an accepted result with the oldest expectation
			if (m_tvalid && m_tready) begin
				got_r.speed          = m_tdata[15:0];
				got_r.average_period = m_tdata[31:16];
				if (speed_expect_q.size() == 0) begin
					$error("result speed=%0d average_period=%0d with no item pending",
						got_r.speed, got_r.average_period);
					errors++;
				end else begin
					exp_r = speed_expect_q.pop_front();
					if (got_r.speed !== exp_r.speed) begin
						$error("speed: expected %0d, got %0d", exp_r.speed, got_r.speed);
						errors++;
					end
					if (got_r.average_period !== exp_r.average_period) begin
						$error("average_period: expected %0d, got %0d",
							exp_r.average_period, got_r.average_period);
						errors++;
					end
				end
			end

			// Predict the result of an accepted item
			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					update_speed_estimate(s_tdata[PER_W-1:0]);
				end
				exp_r.speed          = speed_q;
				exp_r.average_period = avg_q;
				speed_expect_q.push_back(exp_r);
			end
			pending = speed_expect_q.size();
		end
	end

endmodule

FILE: tb/hall_period_speed_estimator_unit_tb.sv
// Testbench top for the Hall period speed estimator: drives items and register
// writes, idles both streams at random. Depends on hpse_pkg and hpse_speed_checker.
`timescale 1ns / 1ps

module hall_period_speed_estimator_unit_tb;
	import hpse_pkg::*;

	localparam logic [1:0] REG_UNUSED  = 2'd3;
	localparam int         QUIET_LIMIT = 1000;
	localparam int         SETTLE_CYC  = 24;
	localparam int         RAND_PHASES = 12;
	localparam int         PHASE_ITEMS = 153;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [15:0]       s_tdata;  // [15:0] period
	logic              s_tuser;  // [0] new_capture
	logic              m_tvalid;
	logic              m_tready;
	logic [31:0]       m_tdata;  // [15:0] speed, [31:16] average_period
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int chk_errors;
	int chk_pending;
	int quiet_cyc;
	bit steady;

	hall_period_speed_estimator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	hpse_speed_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.errors   (chk_errors),
		.pending  (chk_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cyc <= 0;
		end else if (quiet_cyc >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cyc <= quiet_cyc + 1;
		end
	end

	// Result side: random stall before each item unless in a steady stretch
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// APB write: setup phase, access phase, then the bus is released and left idle before returning
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one item after a random gap, return once it is taken
	task automatic send_item(input logic cap, input logic [15:0] per);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= per;
		s_tuser  <= cap;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stop sending until every pending result is back, then let the block settle
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (chk_pending != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic random_setup();
		logic [15:0] lo;
		logic [15:0] hi;
		logic [31:0] k;
		case ($urandom_range(0, 9))
			0: begin
				lo = 16'd1;
				hi = 16'hFFFF;
			end
			1: begin
				lo = 16'($urandom_range(1, 65535));
				hi = lo;
			end
			2: begin
				// crossed bounds
				hi = 16'($urandom_range(1, 30000));
				lo = 16'($urandom_range(hi + 1, 65535));
			end
			3: begin
				lo = 16'd0;
				hi = 16'($urandom_range(0, 50));
			end
			default: begin
				lo = 16'($urandom_range(1, 3000));
				hi = 16'($urandom_range(lo, 65535));
			end
		endcase
		case ($urandom_range(0, 5))
			0: k = $urandom;
			1: k = $urandom_range(0, 65535);
			2: k = 32'hFFFF_FFFF - $urandom_range(0, 1000);
			3: k = 32'd0;
			default: k = $urandom_range(100000, 50000000);
		endcase
		reg_write(REG_PERIOD_LO, {16'($urandom), lo});
		reg_write(REG_PERIOD_HI, {16'($urandom), hi});
		reg_write(REG_SPEED_CONSTANT, k);
		if ($urandom_range(0, 3) == 0) begin
			reg_write(REG_UNUSED, $urandom);
		end
	endtask

	initial begin
		int          base;
		int          jit;
		int          per_i;
		logic        cap;
		logic [15:0] per;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		steady   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: empty state, climb to the longest period
		send_item(1'b0, 16'hFFFF);
		send_item(1'b1, 16'h0000);
		send_item(1'b1, 16'hFFFF);
		send_item(1'b1, 16'hFFFF);
		send_item(1'b1, 16'hFFFF);
		send_item(1'b1, 16'hFFFF);
		send_item(1'b1, 16'h5555);
		send_item(1'b1, 16'hAAAA);
		send_item(1'b0, 16'h1234);
		hold_until_drained();

		// Widest bounds and largest dividend: quotient overflow
		reg_write(REG_PERIOD_LO, 32'hFFFF_0001);
		reg_write(REG_PERIOD_HI, 32'h0000_FFFF);
		reg_write(REG_SPEED_CONSTANT, 32'hFFFF_FFFF);
		reg_write(REG_UNUSED, 32'h0000_0000);
		send_item(1'b1, 16'h0001);
		send_item(1'b1, 16'h0000);
		send_item(1'b1, 16'h0000);
		send_item(1'b1, 16'h8000);
		hold_until_drained();

		// Both bounds zero: zero divisor
		reg_write(REG_PERIOD_LO, 32'h5A5A_0000);
		reg_write(REG_PERIOD_HI, 32'h0000_0000);
		send_item(1'b1, 16'h7FFF);
		send_item(1'b0, 16'h0000);
		hold_until_drained();

		// Crossed bounds
		reg_write(REG_PERIOD_LO, 32'd5000);
		reg_write(REG_PERIOD_HI, 32'd200);
		reg_write(REG_SPEED_CONSTANT, 32'd1000000);
		send_item(1'b1, 16'h0000);
		send_item(1'b1, 16'h0000);
		send_item(1'b1, 16'hFFFF);
		hold_until_drained();

		// Zero dividend
		reg_write(REG_SPEED_CONSTANT, 32'd0);
		send_item(1'b1, 16'd1000);
		send_item(1'b1, 16'hFFFF);
		send_item(1'b0, 16'h0000);
		hold_until_drained();

		// Random phases: a drifting motor period with jitter, plus noise
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			random_setup();
			steady = ($urandom_range(0, 3) == 0);
			base = $urandom_range(0, 65535);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 40) == 0) begin
					base = $urandom_range(0, 65535);
				end
				base += int'($urandom_range(0, 200)) - 100;
				base = (base < 0) ? 0 : ((base > 65535) ? 65535 : base);
				case ($urandom_range(0, 15))
					0: per_i = $urandom_range(0, 65535);
					1: per_i = ($urandom_range(0, 1) == 0) ? 0 : 65535;
					default: begin
						jit = base / 16 + 1;
						per_i = base + int'($urandom_range(0, 2 * jit)) - jit;
					end
				endcase
				per_i = (per_i < 0) ? 0 : ((per_i > 65535) ? 65535 : per_i);
				per = 16'(per_i);
				cap = ($urandom_range(0, 3) != 0);
				send_item(cap, per);
				if ($urandom_range(0, 20) == 0) begin
					steady = !steady;
				end
			end
			hold_until_drained();
		end

		steady = 1'b0;
		if (chk_errors == 0 && chk_pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/hpse_pkg.sv
hw/rtl/hpse_regs.sv
hw/rtl/hpse_ctrl.sv
hw/rtl/hpse_dp.sv
hw/rtl/hall_period_speed_estimator_unit.sv
tb/hpse_speed_checker.sv
tb/hall_period_speed_estimator_unit_tb.sv
